FILE: hw/rtl/sotrig_pkg.sv
// Package for the stop order trigger table.
// Holds the transaction kind codes, the assist type codes and the structs
// passed between the control logic and the slot cells. No dependencies.
`timescale 1ns / 1ps

package sotrig_pkg;

    // Counter width that covers up to 16 slots plus one.
    localparam int CNT_W = 5;

    // Transaction kinds.
    localparam logic [2:0] KIND_ADD         = 3'd0;
    localparam logic [2:0] KIND_REMOVE_TYPE = 3'd1;
    localparam logic [2:0] KIND_REMOVE_ALL  = 3'd2;
    localparam logic [2:0] KIND_REMOVE_SIDE = 3'd3;
    localparam logic [2:0] KIND_TICK        = 3'd4;

    // Assist pair order types.
    localparam logic [2:0] TYPE_ASSIST_BUY  = 3'd2;
    localparam logic [2:0] TYPE_ASSIST_SELL = 3'd3;

    // Side codes.
    localparam logic SIDE_BUY = 1'b0;

    // Command broadcast to every cell during a scan.
    typedef struct packed {
        logic        side;
        logic [31:0] price;
    } cmd_t;

    // Partial result handed from one cell to the next.
    typedef struct packed {
        logic [CNT_W-1:0] pos;
        logic             dup;
        logic [CNT_W-1:0] held;
        logic [CNT_W-1:0] side_cnt;
        logic             hit;
        logic [CNT_W-1:0] hit_pos;
        logic             hit_side;
        logic [31:0]      hit_price;
        logic [31:0]      hit_qty;
    } scan_t;

    // Update broadcast to every cell at the end of a transaction.
    typedef struct packed {
        logic        wr;
        logic        clr_all;
        logic        clr_side;
        logic        side;
        logic [31:0] price;
        logic [31:0] qty;
    } commit_t;

endpackage

FILE: hw/rtl/sotrig_cell.sv
// One slot cell of the stop order trigger table.
// Stores one order and folds its contribution into the scan record passed
// down the chain. Depends on sotrig_pkg.
`timescale 1ns / 1ps

module sotrig_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  sotrig_pkg::cmd_t    cmd,
    input  sotrig_pkg::scan_t   scan_in,
    output sotrig_pkg::scan_t   scan_out,
    input  sotrig_pkg::commit_t commit,
    input  logic                wr_sel,
    input  logic                clr_sel,
    output logic                valid
);
    import sotrig_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    logic        side_reg;
    logic [31:0] price_reg;
    logic [31:0] qty_reg;
    scan_t       scan_reg;
    scan_t       scan_next;
    logic        same_side;
    logic        trig;

    assign same_side = valid_reg && (side_reg == cmd.side);

    // A buy stop triggers at or above its price, a sell stop at or below.
    assign trig = valid_reg &&
                  ((side_reg == SIDE_BUY) ? (price_reg <= cmd.price)
                                          : (price_reg >= cmd.price));

    // Fold this slot into the record from the previous cell.
    always_comb
    begin
        scan_next          = scan_in;
        scan_next.pos      = scan_in.pos + CNT_W'(1);
        scan_next.dup      = scan_in.dup || (same_side && (price_reg == cmd.price));
        scan_next.held     = scan_in.held + CNT_W'(valid_reg);
        scan_next.side_cnt = scan_in.side_cnt + CNT_W'(same_side);
        if (!scan_in.hit && trig)
        begin
            scan_next.hit       = 1'b1;
            scan_next.hit_pos   = scan_in.pos;
            scan_next.hit_side  = side_reg;
            scan_next.hit_price = price_reg;
            scan_next.hit_qty   = qty_reg;
        end
    end

    // Valid bit update at commit time.
    always_comb
    begin
        valid_next = valid_reg;
        if (commit.clr_all || clr_sel || (commit.clr_side && same_side))
        begin
            valid_next = 1'b0;
        end
        if (commit.wr && wr_sel)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Order payload and the scan record need no reset.
    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
        if (commit.wr && wr_sel)
        begin
            side_reg  <= commit.side;
            price_reg <= commit.price;
            qty_reg   <= commit.qty;
        end
    end

    assign scan_out = scan_reg;
    assign valid    = valid_reg;

endmodule

FILE: hw/rtl/stop_order_trigger_table.sv
// Stop order trigger table: a chain of NUM_SLOTS slot cells with a control unit.
// An accepted transaction is scanned while its record passes through the cell chain
// one cell per cycle, then committed; the commit waits while an unread result is
// held. A new transaction is accepted only once the last one has committed.
// Reset clears all slot valid bits and the control state; the result register
// lets the next transaction start while a result waits. Depends on sotrig_pkg.
`timescale 1ns / 1ps

module stop_order_trigger_table #(
    parameter int NUM_SLOTS = 5
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  kind,
    input  logic [2:0]  order_type,
    input  logic        side,
    input  logic [31:0] price,
    input  logic [31:0] quantity,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  count,
    output logic        accepted,
    output logic        fired,
    output logic [2:0]  fired_type,
    output logic        fired_side,
    output logic [31:0] fired_price,
    output logic [31:0] fired_quantity,
    output logic [4:0]  valid_mask
);
    import sotrig_pkg::*;

    localparam int SCAN_W = $clog2(NUM_SLOTS);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [SCAN_W-1:0] scan_cnt_reg;
    logic [SCAN_W-1:0] scan_cnt_next;

    logic [2:0]        kind_reg;
    logic [2:0]        type_reg;
    logic              side_reg;
    logic [31:0]       price_reg;
    logic [31:0]       qty_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [2:0]        count_reg;
    logic              accepted_reg;
    logic              fired_reg;
    logic [2:0]        fired_type_reg;
    logic              fired_side_reg;
    logic [31:0]       fired_price_reg;
    logic [31:0]       fired_qty_reg;

    cmd_t              cmd;
    commit_t           commit;
    scan_t             seed;
    scan_t             scan_chain [NUM_SLOTS];
    scan_t             fin;
    logic [NUM_SLOTS-1:0] valid_vec;
    logic [NUM_SLOTS-1:0] wr_sel;
    logic [NUM_SLOTS-1:0] clr_sel;
    logic [NUM_SLOTS+4:0] valid_ext;

    logic                 accept_in;
    logic                 commit_go;
    logic                 type_ok;
    logic                 add_ok;
    logic [NUM_SLOTS-1:0] type_mask;
    logic [NUM_SLOTS-1:0] partner_mask;
    logic [NUM_SLOTS-1:0] fire_mask;
    logic [NUM_SLOTS-1:0] fire_partner_mask;
    logic [CNT_W-1:0]     fire_type;
    logic [CNT_W-1:0]     count_calc;

    assign accept_in = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign commit_go = (state_reg == ST_COMMIT) && (!out_valid_reg || out_ready);

    // The command stays stable for the whole scan.
    assign cmd.side  = side_reg;
    assign cmd.price = price_reg;
    assign seed      = '0;

    // Row of slot cells; each passes its scan record to the next.
    for (genvar i = 0; i < NUM_SLOTS; i++)
    begin : g_cell
        sotrig_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd),
            .scan_in  ((i == 0) ? seed : scan_chain[(i == 0) ? 0 : i - 1]),
            .scan_out (scan_chain[i]),
            .commit   (commit),
            .wr_sel   (wr_sel[i]),
            .clr_sel  (clr_sel[i]),
            .valid    (valid_vec[i])
        );
    end

    assign fin = scan_chain[NUM_SLOTS-1];

    // Slot masks for the requested type, its assist partner and the fired slot.
    assign type_ok   = (type_reg != 3'd0) && ({29'd0, type_reg} <= 32'(NUM_SLOTS));
    assign type_mask = type_ok ? (NUM_SLOTS'(1) << (type_reg - 3'd1)) : '0;
    always_comb
    begin
        partner_mask = '0;
        if (type_reg == TYPE_ASSIST_BUY)
        begin
            partner_mask = NUM_SLOTS'(1) << (TYPE_ASSIST_SELL - 3'd1);
        end
        else if (type_reg == TYPE_ASSIST_SELL)
        begin
            partner_mask = NUM_SLOTS'(1) << (TYPE_ASSIST_BUY - 3'd1);
        end
    end

    assign fire_type = fin.hit_pos + CNT_W'(1);
    assign fire_mask = fin.hit ? (NUM_SLOTS'(1) << fin.hit_pos) : '0;
    always_comb
    begin
        fire_partner_mask = '0;
        if (fin.hit && (fire_type == CNT_W'(TYPE_ASSIST_BUY)))
        begin
            fire_partner_mask = NUM_SLOTS'(1) << (TYPE_ASSIST_SELL - 3'd1);
        end
        else if (fin.hit && (fire_type == CNT_W'(TYPE_ASSIST_SELL)))
        begin
            fire_partner_mask = NUM_SLOTS'(1) << (TYPE_ASSIST_BUY - 3'd1);
        end
    end

    assign add_ok = !fin.dup && type_ok;

    // Commit decode from the finished scan record.
    always_comb
    begin
        commit          = '0;
        commit.side     = side_reg;
        commit.price    = price_reg;
        commit.qty      = qty_reg;
        wr_sel          = '0;
        clr_sel         = '0;
        count_calc      = '0;
        case (kind_reg)
            KIND_ADD:
            begin
                commit.wr  = commit_go && add_ok;
                wr_sel     = type_mask;
                count_calc = fin.held +
                             CNT_W'(add_ok && !(|(valid_vec & type_mask)));
            end
            KIND_REMOVE_TYPE:
            begin
                clr_sel    = commit_go ? (type_mask | partner_mask) : '0;
                count_calc = CNT_W'(|(valid_vec & type_mask)) +
                             CNT_W'(|(valid_vec & partner_mask));
            end
            KIND_REMOVE_ALL:
            begin
                commit.clr_all = commit_go;
                count_calc     = fin.held;
            end
            KIND_REMOVE_SIDE:
            begin
                commit.clr_side = commit_go;
                count_calc      = fin.side_cnt;
            end
            KIND_TICK:
            begin
                clr_sel = commit_go ? (fire_mask | fire_partner_mask) : '0;
            end
            default:
            begin
                count_calc = '0;
            end
        endcase
    end

    // Sequencer: idle, scan through the chain, then commit.
    always_comb
    begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                scan_cnt_next = '0;
                if (accept_in)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + SCAN_W'(1);
                if (scan_cnt_reg == SCAN_W'(NUM_SLOTS - 1))
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (commit_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The result is held until the output transaction completes.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_cnt_reg  <= scan_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Command capture and result registers.
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            kind_reg  <= kind;
            type_reg  <= order_type;
            side_reg  <= side;
            price_reg <= price;
            qty_reg   <= quantity;
        end
        if (commit_go)
        begin
            count_reg       <= count_calc[2:0];
            accepted_reg    <= (kind_reg == KIND_ADD) && add_ok;
            fired_reg       <= (kind_reg == KIND_TICK) && fin.hit;
            fired_type_reg  <= ((kind_reg == KIND_TICK) && fin.hit) ? fire_type[2:0] : 3'd0;
            fired_side_reg  <= (kind_reg == KIND_TICK) && fin.hit_side;
            fired_price_reg <= (kind_reg == KIND_TICK) ? fin.hit_price : 32'd0;
            fired_qty_reg   <= (kind_reg == KIND_TICK) ? fin.hit_qty : 32'd0;
        end
    end

    assign valid_ext      = {5'd0, valid_vec};
    assign valid_mask     = valid_ext[4:0];
    assign out_valid      = out_valid_reg;
    assign count          = count_reg;
    assign accepted       = accepted_reg;
    assign fired          = fired_reg;
    assign fired_type     = fired_type_reg;
    assign fired_side     = fired_side_reg;
    assign fired_price    = fired_price_reg;
    assign fired_quantity = fired_qty_reg;

endmodule

FILE: tb/stop_order_trigger_table_tb.sv
// Self-checking testbench for the stop order trigger table.
// Holds its own model of the slot table and compares every result against it.
// Depends on sotrig_pkg and stop_order_trigger_table.
`timescale 1ns / 1ps

module stop_order_trigger_table_tb;

    import sotrig_pkg::*;

    localparam int SLOT_COUNT  = 5;
    localparam int RANDOM_REQS = 1925;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 20;

    // Kinds with no operation behind them.
    localparam logic [2:0] KIND_SPARE_5 = 3'd5;
    localparam logic [2:0] KIND_SPARE_6 = 3'd6;
    localparam logic [2:0] KIND_SPARE_7 = 3'd7;

    // Order types that name no slot.
    localparam logic [2:0] TYPE_NONE    = 3'd0;
    localparam logic [2:0] TYPE_SPARE_6 = 3'd6;
    localparam logic [2:0] TYPE_SPARE_7 = 3'd7;

    localparam logic SIDE_SELL = 1'b1;

    typedef struct {
        logic [2:0]  kind;
        logic [2:0]  order_type;
        logic        side;
        logic [31:0] price;
        logic [31:0] quantity;
        bit          drain;
    } order_req_t;

    typedef struct {
        logic [2:0]  count;
        logic        accepted;
        logic        fired;
        logic [2:0]  fired_type;
        logic        fired_side;
        logic [31:0] fired_price;
        logic [31:0] fired_quantity;
        logic [4:0]  valid_mask;
    } table_resp_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  kind = KIND_ADD;
    logic [2:0]  order_type = TYPE_NONE;
    logic        side = SIDE_BUY;
    logic [31:0] price = '0;
    logic [31:0] quantity = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  count;
    logic        accepted;
    logic        fired;
    logic [2:0]  fired_type;
    logic        fired_side;
    logic [31:0] fired_price;
    logic [31:0] fired_quantity;
    logic [4:0]  valid_mask;

    // Model copy of the slot table.
    bit          book_held [SLOT_COUNT];
    logic        book_side [SLOT_COUNT];
    logic [31:0] book_price [SLOT_COUNT];
    logic [31:0] book_qty [SLOT_COUNT];

    order_req_t  order_queue[$];
    table_resp_t table_expect[$];

    int          error_count = 0;
    int          items_total = 0;
    int          items_done = 0;
    int          cycle_count = 0;

    // Sender and receiver pacing state.
    order_req_t  tx_item;
    bit          tx_busy;
    bit          tx_offer;
    int          burst_left = 0;
    int          gap_left = 0;
    table_resp_t rx_want;
    int          rx_cycles = 0;
    int          hold_left = 0;
    int          seg_left = 0;
    int          rx_mode = 0;
    bit          rx_ready;

    stop_order_trigger_table #(
        .NUM_SLOTS(SLOT_COUNT)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .order_type    (order_type),
        .side          (side),
        .price         (price),
        .quantity      (quantity),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .count         (count),
        .accepted      (accepted),
        .fired         (fired),
        .fired_type    (fired_type),
        .fired_side    (fired_side),
        .fired_price   (fired_price),
        .fired_quantity(fired_quantity),
        .valid_mask    (valid_mask)
    );

    always #10 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    function automatic int held_total();
        int n;
        n = 0;
        for (int i = 0; i < SLOT_COUNT; i++)
            if (book_held[i])
                n++;
        return n;
    endfunction

    function automatic logic [2:0] assist_mate(input logic [2:0] t);
        if (t == TYPE_ASSIST_BUY)
            return TYPE_ASSIST_SELL;
        if (t == TYPE_ASSIST_SELL)
            return TYPE_ASSIST_BUY;
        return TYPE_NONE;
    endfunction

    // Clears the slot of type t; returns 1 when a held slot was cleared.
    function automatic int clear_type(input logic [2:0] t);
        if (t < 1 || t > SLOT_COUNT)
            return 0;
        if (!book_held[t - 1])
            return 0;
        book_held[t - 1] = 1'b0;
        return 1;
    endfunction

    // Applies one transaction to the model table and returns its result.
    function automatic table_resp_t apply_request(input order_req_t r);
        table_resp_t res;
        bit          dup;
        bit          hit;
        bit          found;
        int          n;
        logic [2:0]  mate;
        res = '{default: '0};
        n = 0;
        case (r.kind)
            KIND_ADD:
            begin
                dup = 1'b0;
                for (int i = 0; i < SLOT_COUNT; i++)
                    if (book_held[i] && book_side[i] == r.side && book_price[i] == r.price)
                        dup = 1'b1;
                if (!dup && r.order_type >= 1 && r.order_type <= SLOT_COUNT)
                begin
                    book_held[r.order_type - 1]  = 1'b1;
                    book_side[r.order_type - 1]  = r.side;
                    book_price[r.order_type - 1] = r.price;
                    book_qty[r.order_type - 1]   = r.quantity;
                    res.accepted = 1'b1;
                end
                n = held_total();
            end
            KIND_REMOVE_TYPE:
            begin
                mate = assist_mate(r.order_type);
                n = clear_type(r.order_type);
                if (mate != TYPE_NONE)
                    n += clear_type(mate);
            end
            KIND_REMOVE_ALL:
            begin
                n = held_total();
                for (int i = 0; i < SLOT_COUNT; i++)
                    book_held[i] = 1'b0;
            end
            KIND_REMOVE_SIDE:
            begin
                for (int i = 0; i < SLOT_COUNT; i++)
                    if (book_held[i] && book_side[i] == r.side)
                    begin
                        book_held[i] = 1'b0;
                        n++;
                    end
            end
            KIND_TICK:
            begin
                // The lowest-numbered triggered slot fires and takes its assist mate along.
                found = 1'b0;
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    if (book_held[i] && !found)
                    begin
                        hit = (book_side[i] == SIDE_BUY) ? (book_price[i] <= r.price)
                                                         : (book_price[i] >= r.price);
                        if (hit)
                        begin
                            found              = 1'b1;
                            res.fired          = 1'b1;
                            res.fired_type     = 3'(i + 1);
                            res.fired_side     = book_side[i];
                            res.fired_price    = book_price[i];
                            res.fired_quantity = book_qty[i];
                            book_held[i]       = 1'b0;
                            mate = assist_mate(3'(i + 1));
                            if (mate != TYPE_NONE)
                                void'(clear_type(mate));
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        res.count = 3'(n);
        for (int i = 0; i < SLOT_COUNT && i < 5; i++)
            res.valid_mask[i] = book_held[i];
        return res;
    endfunction

    task automatic queue_item(input logic [2:0] k, input logic [2:0] t, input logic s,
                              input logic [31:0] p, input logic [31:0] q);
        order_req_t r;
        r.kind       = k;
        r.order_type = t;
        r.side       = s;
        r.price      = p;
        r.quantity   = q;
        r.drain      = 1'b0;
        order_queue.push_back(r);
        items_total++;
    endtask

    // Stimulus: directed cases first, then random transactions, then the final verdict.
    initial
    begin
        order_req_t  r;
        logic [31:0] pool_base;
        int          pick;

        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            book_held[i]  = 1'b0;
            book_side[i]  = SIDE_BUY;
            book_price[i] = '0;
            book_qty[i]   = '0;
        end

        // Empty table, full table, duplicates, overwrite, bad types, spare kinds.
        queue_item(KIND_TICK, 3'd1, SIDE_BUY, 32'd5, 32'd0);
        queue_item(KIND_REMOVE_ALL, 3'd1, SIDE_BUY, 32'd0, 32'd0);
        queue_item(KIND_ADD, 3'd1, SIDE_BUY, 32'd0, 32'd0);
        queue_item(KIND_ADD, TYPE_ASSIST_BUY, SIDE_BUY, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_item(KIND_ADD, TYPE_ASSIST_SELL, SIDE_SELL, 32'd100, 32'd5);
        queue_item(KIND_ADD, 3'd4, SIDE_SELL, 32'd100, 32'd6);
        queue_item(KIND_ADD, 3'd4, SIDE_BUY, 32'd100, 32'd7);
        queue_item(KIND_ADD, TYPE_NONE, SIDE_BUY, 32'd55, 32'd1);
        queue_item(KIND_ADD, TYPE_SPARE_6, SIDE_SELL, 32'd56, 32'd1);
        queue_item(KIND_ADD, TYPE_SPARE_7, SIDE_BUY, 32'd57, 32'd1);
        queue_item(KIND_ADD, 3'd5, SIDE_SELL, 32'hFFFF_FFFF, 32'd1);
        queue_item(KIND_ADD, 3'd1, SIDE_BUY, 32'd0, 32'd3);
        queue_item(KIND_ADD, 3'd1, SIDE_BUY, 32'd7, 32'd9);
        queue_item(KIND_SPARE_5, 3'd1, SIDE_SELL, 32'd7, 32'd9);
        queue_item(KIND_SPARE_6, 3'd2, SIDE_BUY, 32'd100, 32'd1);
        queue_item(KIND_SPARE_7, 3'd5, SIDE_SELL, 32'hFFFF_FFFF, 32'd1);
        queue_item(KIND_REMOVE_TYPE, TYPE_ASSIST_BUY, SIDE_BUY, 32'd0, 32'd0);
        queue_item(KIND_REMOVE_TYPE, TYPE_NONE, SIDE_BUY, 32'd0, 32'd0);
        queue_item(KIND_REMOVE_TYPE, TYPE_SPARE_7, SIDE_SELL, 32'd0, 32'd0);
        queue_item(KIND_TICK, 3'd1, SIDE_BUY, 32'd50, 32'd0);
        queue_item(KIND_ADD, TYPE_ASSIST_SELL, SIDE_SELL, 32'd200, 32'd8);
        queue_item(KIND_ADD, TYPE_ASSIST_BUY, SIDE_BUY, 32'd10, 32'd9);
        queue_item(KIND_TICK, 3'd1, SIDE_BUY, 32'd5, 32'd0);
        queue_item(KIND_TICK, 3'd1, SIDE_SELL, 32'hFFFF_FFFF, 32'd0);
        queue_item(KIND_REMOVE_SIDE, 3'd1, SIDE_SELL, 32'd0, 32'd0);
        queue_item(KIND_ADD, 3'd4, SIDE_BUY, 32'd3, 32'd3);
        queue_item(KIND_REMOVE_SIDE, 3'd1, SIDE_BUY, 32'd0, 32'd0);

        // Random part: prices mostly cluster near a moving base so that duplicates
        // and triggers are common; the rest spans the full range.
        pool_base = $urandom;
        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            if (n % 150 == 0)
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    pool_base = 32'd0;
                else if (pick == 1)
                    pool_base = 32'hFFFF_FFF0;
                else
                    pool_base = $urandom_range(0, 32'hFFFF_FFF0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 40)
                r.kind = KIND_ADD;
            else if (pick < 66)
                r.kind = KIND_TICK;
            else if (pick < 80)
                r.kind = KIND_REMOVE_TYPE;
            else if (pick < 89)
                r.kind = KIND_REMOVE_SIDE;
            else if (pick < 95)
                r.kind = KIND_REMOVE_ALL;
            else
                r.kind = 3'($urandom_range(KIND_SPARE_5, KIND_SPARE_7));
            if ($urandom_range(0, 19) == 0)
                r.order_type = ($urandom_range(0, 2) == 0) ? TYPE_NONE : 3'($urandom_range(6, 7));
            else
                r.order_type = 3'($urandom_range(1, SLOT_COUNT));
            r.side = 1'($urandom_range(0, 1));
            pick = $urandom_range(0, 99);
            if (pick < 65)
                r.price = pool_base + $urandom_range(0, 15);
            else if (pick < 90)
                r.price = $urandom;
            else
                r.price = ($urandom_range(0, 1) == 0) ? 32'd0 : 32'hFFFF_FFFF;
            r.quantity = $urandom;
            r.drain = (n % 400 == 0);
            order_queue.push_back(r);
            items_total++;
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (items_done != items_total || table_expect.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Sender: offers queued transactions in bursts with random gaps between them.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            tx_busy = in_valid;
            if (in_valid && in_ready)
            begin
                table_expect.push_back(apply_request(tx_item));
                items_done++;
                tx_busy = 1'b0;
            end
            if (!tx_busy)
            begin
                tx_offer = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (order_queue.size() > 0
                         && !(order_queue[0].drain && table_expect.size() != 0))
                begin
                    tx_item    = order_queue.pop_front();
                    kind       <= tx_item.kind;
                    order_type <= tx_item.order_type;
                    side       <= tx_item.side;
                    price      <= tx_item.price;
                    quantity   <= tx_item.quantity;
                    tx_offer   = 1'b1;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left--;
                end
                in_valid <= tx_offer;
            end
        end
    end

    // Receiver: checks each result against the oldest expectation and stalls on its
    // own pattern, with two long hold-offs that back the block up.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_cycles = 0;
            hold_left = 0;
            seg_left  = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (table_expect.size() == 0)
                    report_mismatch("result arrived with no transaction pending");
                else
                begin
                    rx_want = table_expect.pop_front();
                    check_field("count", count, rx_want.count);
                    check_field("accepted", accepted, rx_want.accepted);
                    check_field("fired", fired, rx_want.fired);
                    check_field("fired_type", fired_type, rx_want.fired_type);
                    check_field("fired_side", fired_side, rx_want.fired_side);
                    check_field("fired_price", fired_price, rx_want.fired_price);
                    check_field("fired_quantity", fired_quantity, rx_want.fired_quantity);
                    check_field("valid_mask", valid_mask, rx_want.valid_mask);
                end
            end

            rx_cycles++;
            if (rx_cycles == 2500 || rx_cycles == 15000)
                hold_left = 300;
            if (hold_left > 0)
            begin
                hold_left--;
                rx_ready = 1'b0;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    rx_mode  = $urandom_range(0, 3);
                    seg_left = $urandom_range(10, 80);
                end
                seg_left--;
                case (rx_mode)
                    0: rx_ready = 1'b1;
                    1: rx_ready = 1'($urandom_range(0, 1));
                    2: rx_ready = ($urandom_range(0, 3) == 0);
                    default: rx_ready = rx_cycles[1];
                endcase
            end
            out_ready <= rx_ready;
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

endmodule
